@@ rtl/lsbp_pkg.sv @@
// Package for the linear sum bound pruning block.
// Holds the transfer types and codes used by the front, back, top and checker modules; depends on nothing.
package lsbp_pkg;

    localparam logic KIND_UPPER = 1'b0;
    localparam logic KIND_LOWER = 1'b1;

    typedef struct packed {
        logic signed [47:0] sum_limit;
        logic signed [47:0] fixed_total;
        logic signed [47:0] min_remaining;
        logic [10:0]        skip_index;
        logic [9:0]         term_index;
        logic [19:0]        variable_id;
        logic signed [31:0] coefficient;
        logic signed [31:0] var_low;
        logic signed [31:0] var_high;
        logic               is_fixed;
    } in_t;

    typedef struct packed {
        logic [19:0]        target_variable;
        logic               bound_kind;
        logic signed [63:0] new_bound;
    } out_t;

    // A classified term waiting for division.
    typedef struct packed {
        logic signed [63:0] avail;
        logic [31:0]        dmag;
        logic               neg_c;
        logic [19:0]        vid;
        logic signed [31:0] thresh;
    } work_t;

endpackage

@@ rtl/lsbp_queue.sv @@
// Small register queue used between the front and back parts and at the output.
// Depends on nothing but its type parameter.
module lsbp_queue #(
    parameter type T = logic,
    parameter int  DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);
    localparam int AW = $clog2(DEPTH);

    T               mem [DEPTH];
    logic [AW-1:0]  wr_reg;
    logic [AW-1:0]  rd_reg;
    logic [AW:0]    cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule

@@ rtl/lsbp_front.sv @@
// Front part: accepts terms, drops those that give no result, forms the available sum.
// Depends on lsbp_pkg.
module lsbp_front #(
    parameter int MAX_TERMS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lsbp_pkg::in_t  term,
    output logic           full,
    output logic           wpush,
    output lsbp_pkg::work_t wdata,
    input  logic           wfull
);
    import lsbp_pkg::*;

    logic               en;
    logic               drop;
    logic               neg_c;
    logic               s1_v_reg;
    logic signed [49:0] s1_diff_reg;
    logic signed [63:0] s1_prod_reg;
    logic [31:0]        s1_dmag_reg;
    logic               s1_negc_reg;
    logic [19:0]        s1_vid_reg;
    logic signed [31:0] s1_th_reg;
    logic               s2_v_reg;
    work_t              s2_reg;

    assign en    = !(s2_v_reg && wfull);
    assign full  = !en;
    assign neg_c = term.coefficient[31];
    assign drop  = ((32'(term.skip_index) < 32'(MAX_TERMS))
                    && (term.skip_index == {1'b0, term.term_index}))
                   || term.is_fixed || (term.coefficient == '0);
    assign wpush = s2_v_reg;
    assign wdata = s2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_diff_reg <= 50'(term.sum_limit) - 50'(term.fixed_total)
                           - 50'(term.min_remaining);
            s1_prod_reg <= 64'(term.coefficient)
                           * 64'(neg_c ? term.var_high : term.var_low);
            s1_dmag_reg <= neg_c ? 32'(-term.coefficient) : term.coefficient;
            s1_negc_reg <= neg_c;
            s1_vid_reg  <= term.variable_id;
            s1_th_reg   <= neg_c ? term.var_low : term.var_high;
            s2_reg.avail  <= 64'(s1_diff_reg) + s1_prod_reg;
            s2_reg.dmag   <= s1_dmag_reg;
            s2_reg.neg_c  <= s1_negc_reg;
            s2_reg.vid    <= s1_vid_reg;
            s2_reg.thresh <= s1_th_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= push && !drop;
            s2_v_reg <= s1_v_reg;
        end
    end
endmodule

@@ rtl/lsbp_back.sv @@
// Back part: one quotient bit per stage of a restoring divider, then rounding and the tightening test.
// Depends on lsbp_pkg.
module lsbp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wempty,
    input  lsbp_pkg::work_t wdata,
    output logic            wpop,
    output logic            opush,
    output lsbp_pkg::out_t  odata,
    input  logic            ofull
);
    import lsbp_pkg::*;

    localparam int NS = 64;

    logic               v_reg   [NS+1];
    logic [31:0]        rem_reg [NS+1];
    logic [63:0]        aq_reg  [NS+1];
    logic [31:0]        dm_reg  [NS+1];
    logic               na_reg  [NS+1];
    logic               nc_reg  [NS+1];
    logic [19:0]        vid_reg [NS+1];
    logic signed [31:0] th_reg  [NS+1];
    logic [31:0]        rem_next [NS];
    logic [63:0]        aq_next  [NS];

    logic               fin_v_reg;
    logic signed [63:0] fin_nb_reg;
    logic               fin_nc_reg;
    logic [19:0]        fin_vid_reg;
    logic signed [31:0] fin_th_reg;

    logic               en;
    logic               rnz;
    logic               inc;
    logic [63:0]        base;
    logic               tight;

    assign en   = !(fin_v_reg && ofull);
    assign wpop = en && !wempty;

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            logic [32:0] trial;
            logic        ge;
            trial = {rem_reg[k], aq_reg[k][63]};
            ge    = trial >= {1'b0, dm_reg[k]};
            rem_next[k] = ge ? 32'(trial - {1'b0, dm_reg[k]}) : trial[31:0];
            aq_next[k]  = {aq_reg[k][62:0], ge};
        end
    end

    // Floor of the signed quotient, negated for a negative coefficient, folded into one add.
    assign rnz  = (rem_reg[NS] != '0);
    assign base = (na_reg[NS] ^ nc_reg[NS]) ? ~aq_reg[NS] : aq_reg[NS];
    assign inc  = na_reg[NS] ? (nc_reg[NS] ? rnz : !rnz) : nc_reg[NS];

    assign tight = fin_nc_reg ? (fin_nb_reg > 64'(fin_th_reg))
                              : (fin_nb_reg < 64'(fin_th_reg));
    assign opush = fin_v_reg && tight && !ofull;
    assign odata.target_variable = fin_vid_reg;
    assign odata.bound_kind      = fin_nc_reg ? KIND_LOWER : KIND_UPPER;
    assign odata.new_bound       = fin_nb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            aq_reg[0]  <= wdata.avail[63] ? 64'(-wdata.avail) : wdata.avail;
            dm_reg[0]  <= wdata.dmag;
            na_reg[0]  <= wdata.avail[63];
            nc_reg[0]  <= wdata.neg_c;
            vid_reg[0] <= wdata.vid;
            th_reg[0]  <= wdata.thresh;
            for (int k = 0; k < NS; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                aq_reg[k+1]  <= aq_next[k];
                dm_reg[k+1]  <= dm_reg[k];
                na_reg[k+1]  <= na_reg[k];
                nc_reg[k+1]  <= nc_reg[k];
                vid_reg[k+1] <= vid_reg[k];
                th_reg[k+1]  <= th_reg[k];
            end
            fin_nb_reg  <= base + 64'(inc);
            fin_nc_reg  <= nc_reg[NS];
            fin_vid_reg <= vid_reg[NS];
            fin_th_reg  <= th_reg[NS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            fin_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= !wempty;
            for (int k = 0; k < NS; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
            fin_v_reg <= v_reg[NS];
        end
    end
endmodule

@@ rtl/linear_sum_bound_pruning_top.sv @@
// Top level of the linear sum bound pruning block.
// Depends on lsbp_pkg, lsbp_front, lsbp_queue and lsbp_back.
//
//  channel | ports                 | transfer when
//  --------+-----------------------+----------------------
//  terms   | push, full, term      | push high, full low
//  results | pop, empty, result    | pop high, empty low
//
// One term is accepted every cycle while full is low; on its way to a result a term
// passes the front stages, the work queue, 65 divider stages, the rounding stage and
// the output queue.
// Reset clears all valid flags and queue pointers; nothing else needs clearing.
// A stalled output freezes the divider, and the four-entry queue lets the front keep
// accepting until it fills.
module linear_sum_bound_pruning_top #(
    parameter int MAX_TERMS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  lsbp_pkg::in_t  term,
    output logic           empty,
    input  logic           pop,
    output lsbp_pkg::out_t result
);
    import lsbp_pkg::*;

    logic  wpush;
    logic  wfull;
    logic  wpop;
    logic  wempty;
    work_t win;
    work_t wout;
    logic  opush;
    logic  ofull;
    out_t  oin;

    lsbp_front #(.MAX_TERMS(MAX_TERMS)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .term  (term),
        .full  (full),
        .wpush (wpush),
        .wdata (win),
        .wfull (wfull)
    );

    lsbp_queue #(.T(work_t), .DEPTH(4)) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (wpush),
        .wdata (win),
        .full  (wfull),
        .pop   (wpop),
        .rdata (wout),
        .empty (wempty)
    );

    lsbp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .wempty (wempty),
        .wdata  (wout),
        .wpop   (wpop),
        .opush  (opush),
        .odata  (oin),
        .ofull  (ofull)
    );

    lsbp_queue #(.T(out_t), .DEPTH(2)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (opush),
        .wdata (oin),
        .full  (ofull),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );
endmodule

@@ rtl/lsbp_checker.sv @@
// Port-level checks for the linear sum bound pruning block, bound to the top level.
// Depends on lsbp_pkg.
module lsbp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input lsbp_pkg::out_t result
);
    import lsbp_pkg::*;

    // A waiting result that is not taken holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("result changed while waiting");

    // The result queue is still empty at the first edge after reset.
    a_rst_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result queue not empty after reset");

    // The front cannot be full in the cycle after reset.
    a_rst_full: assert property (@(posedge clk)
        !rst_n |=> !full)
        else $error("full asserted after reset");

    // A result cannot appear right after reset has left the result queue empty.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(empty) && $past(!rst_n, 2)) |-> empty)
        else $error("result appeared too early");
endmodule

bind linear_sum_bound_pruning_top lsbp_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
